@@ hdl/lsf_pkg.sv @@
// ============================================================================
// lsf_pkg: shared definitions for the lamp start-up flicker block
// Widths, register indexes, opcodes, reset values and the constant
// functions that build the exponential and logistic lookup tables.
// ============================================================================
package lsf_pkg;

   // Default sizes for the top-level parameters.
   localparam int LAMPS_DEFAULT     = 4;
   localparam int EXP_DEPTH_DEFAULT = 4096;
   localparam int SIG_DEPTH_DEFAULT = 512;

   // Field widths.
   localparam int OUT_LAMPS   = 4;
   localparam int RAND_W      = 10;
   localparam int PERMILLE_W  = 10;
   localparam int DUR_W       = 16;
   localparam int PERIOD_W    = 8;
   localparam int TAU_W       = 16;
   localparam int ELAPSED_W   = 17;
   localparam int SINCE_W     = 9;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int Q16_W       = 17;
   localparam int Q16_SHIFT   = 16;
   localparam int THR_W       = 27;
   localparam int ROM_SHIFT   = 24;

   localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX   = '1;
   localparam logic [SINCE_W-1:0]    SINCE_MAX     = '1;
   localparam logic [Q16_W-1:0]      Q16_ONE       = 17'd65536;
   localparam logic [PERMILLE_W-1:0] PERMILLE_FULL = 10'd1000;
   localparam logic [63:0]           Q30_ONE       = 64'd1 << 30;

   // Opcodes of an input transaction.
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_END_ON      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_DURATION    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHECK_PER   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ON_FLOOR    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFF_START   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_TAU_ON      = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] CSR_TAU_OFF     = 3'd6;

   // Configuration reset values.
   localparam logic                  END_ON_RST    = 1'b1;
   localparam logic [DUR_W-1:0]      DURATION_RST  = 16'd7000;
   localparam logic [PERIOD_W-1:0]   CHECK_PER_RST = 8'd25;
   localparam logic [PERMILLE_W-1:0] ON_FLOOR_RST  = 10'd70;
   localparam logic [PERMILLE_W-1:0] OFF_START_RST = 10'd1000;
   localparam logic [TAU_W-1:0]      TAU_ON_RST    = 16'd2254;
   localparam logic [TAU_W-1:0]      TAU_OFF_RST   = 16'd839;

   // exp(-x) in Q16 for x in Q20 below 16. Evaluated in Q30 as a short
   // Taylor series of exp(-x/256) followed by eight rounded squarings.
   // Used only at elaboration to fill the tables.
   function automatic logic [63:0] exp_neg_q16(input logic [63:0] x_q20);
      logic [63:0] u;
      logic [63:0] sum;
      logic [63:0] term;
      u    = x_q20 << 2;
      sum  = Q30_ONE;
      term = Q30_ONE;
      term = (term * u) >> 30;
      sum  = sum - term;
      term = ((term * u) >> 30) / 64'd2;
      sum  = sum + term;
      term = ((term * u) >> 30) / 64'd3;
      sum  = sum - term;
      term = ((term * u) >> 30) / 64'd4;
      sum  = sum + term;
      term = ((term * u) >> 30) / 64'd5;
      sum  = sum - term;
      for (int n = 0; n < 8; n++) begin
         sum = (sum * sum + (Q30_ONE >> 1)) >> 30;
      end
      return (sum + 64'd8192) >> 14;
   endfunction

   // Logistic entry 2^32 / (1.0 + e) by restoring long division.
   // Used only at elaboration to fill the tables.
   function automatic logic [63:0] sig_entry(input logic [63:0] e_q16);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] quo;
      num = 64'd1 << 32;
      den = 64'(Q16_ONE) + e_q16;
      rem = '0;
      quo = '0;
      for (int b = 32; b >= 0; b--) begin
         rem = (rem << 1) | ((num >> b) & 64'd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (64'd1 << b);
         end
      end
      return quo;
   endfunction

endpackage

@@ hdl/lamp_startup_flicker_core.sv @@
// ============================================================================
// lamp_startup_flicker_core: fluorescent-tube start-up flicker sequencer
// Tracks elapsed time over millisecond ticks, runs periodic random threshold
// checks per lamp against logistic and decaying curves, and forces the final
// lamp state once the flicker phase has run out.
// ============================================================================
// Usage:
//   req_* carries one transaction per item: opcode start (restart the phase)
//   or tick (one millisecond), plus one random draw per lamp. rsp_* returns one
//   transaction per item with the lamp states, the lamps that toggled, whether
//   a threshold check ran and whether the phase has ended. csr_* writes the
//   configuration registers; write them only while the block is idle.
//   An item without a check is swept over the lamps and then loaded into the
//   output register; a tick that runs a check first passes the two-multiply
//   index pipeline, the registered table reads and the threshold multiplies.
//   Throughput: one item at a time; the lamp states sit in a small synchronous
//   memory that is swept one lamp per cycle in a read-modify-write pass.
//   req_ready returns in the cycle after the result is loaded, so a new item
//   is accepted only once the previous one has reached the output register.
//   The output register holds a finished result, so req_ready returns while
//   the receiver stalls; the next result then waits until the held one is
//   taken. Reset restores the default configuration, turns every lamp off and
//   clears the phase state; the lamp memory is covered by per-lamp valid bits.
// ============================================================================
module lamp_startup_flicker_core
   import lsf_pkg::*;
#(
   parameter int NUM_LAMPS       = LAMPS_DEFAULT,
   parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEFAULT,
   parameter int SIG_TABLE_DEPTH = SIG_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [RAND_W-1:0]     req_rand_lamp0,
   input  logic [RAND_W-1:0]     req_rand_lamp1,
   input  logic [RAND_W-1:0]     req_rand_lamp2,
   input  logic [RAND_W-1:0]     req_rand_lamp3,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_LAMPS-1:0]  rsp_lamp_states,
   output logic [OUT_LAMPS-1:0]  rsp_toggled_mask,
   output logic                  rsp_checked,
   output logic                  rsp_done_res,
   // Configuration port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int LAMP_AW = (NUM_LAMPS > 1) ? $clog2(NUM_LAMPS) : 1;
   localparam int LAMP_CW = $clog2(NUM_LAMPS + 1);
   localparam int EXP_AW  = $clog2(EXP_TABLE_DEPTH);
   localparam int SIG_AW  = $clog2(SIG_TABLE_DEPTH);
   localparam int A_W     = ELAPSED_W + TAU_W;
   localparam int EXP_SCW = A_W + $clog2(EXP_TABLE_DEPTH + 1);
   localparam int SIG_SCW = A_W + $clog2(SIG_TABLE_DEPTH + 1);
   localparam int EXP_IW  = EXP_SCW - ROM_SHIFT;
   localparam int SIG_IW  = SIG_SCW - ROM_SHIFT;

   // Sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL1  = 3'd1;
   localparam logic [2:0] S_MUL2  = 3'd2;
   localparam logic [2:0] S_ROM   = 3'd3;
   localparam logic [2:0] S_THR1  = 3'd4;
   localparam logic [2:0] S_THR2  = 3'd5;
   localparam logic [2:0] S_SWEEP = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   // What the lamp sweep does to each lamp
   localparam logic [1:0] MODE_KEEP  = 2'd0;
   localparam logic [1:0] MODE_FORCE = 2'd1;
   localparam logic [1:0] MODE_CHECK = 2'd2;

   // Configuration registers
   logic                  end_on_ff;
   logic [DUR_W-1:0]      duration_ff;
   logic [PERIOD_W-1:0]   check_per_ff;
   logic [PERMILLE_W-1:0] on_floor_ff;
   logic [PERMILLE_W-1:0] off_start_ff;
   logic [TAU_W-1:0]      tau_on_ff;
   logic [TAU_W-1:0]      tau_off_ff;

   // Phase state
   logic [2:0]            state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic                  running_ff, running_in;
   logic [ELAPSED_W-1:0]  elapsed_ff, elapsed_in;
   logic [SINCE_W-1:0]    since_ff, since_in;

   // Item snapshot and threshold pipeline
   logic [RAND_W-1:0]     rand_ff [OUT_LAMPS];
   logic [ELAPSED_W-1:0]  elapsed_snap_ff;
   logic [ELAPSED_W-1:0]  mag_ff;
   logic                  neg_ff;
   logic [A_W-1:0]        a_off_ff;
   logic [A_W-1:0]        a_on_ff;
   logic [EXP_SCW-1:0]    sc_off_ff;
   logic [SIG_SCW-1:0]    sc_on_ff;
   logic [Q16_W-1:0]      exp_q_ff;
   logic [Q16_W-1:0]      sig_q_ff;
   logic [THR_W-1:0]      thr_off_ff;
   logic [THR_W-1:0]      thr_on_ff;
   logic [Q16_W-1:0]      s_adj_ff;

   // Lamp memory and sweep
   logic                  lamp_mem [NUM_LAMPS];
   logic [NUM_LAMPS-1:0]  lamp_vld_ff;
   logic                  lamp_rd_ff;
   logic                  lamp_rd_vld_ff;
   logic [LAMP_CW-1:0]    rd_cnt_ff;
   logic                  pend_vld_ff;
   logic [LAMP_AW-1:0]    pend_idx_ff;
   logic [OUT_LAMPS-1:0]  before_ff;
   logic [OUT_LAMPS-1:0]  after_ff;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_LAMPS-1:0]  rsp_states_ff;
   logic [OUT_LAMPS-1:0]  rsp_toggled_ff;
   logic                  rsp_checked_ff;
   logic                  rsp_done_ff;

   // Lookup tables
   logic [Q16_W-1:0]      exp_rom [EXP_TABLE_DEPTH];
   logic [Q16_W-1:0]      sig_rom [SIG_TABLE_DEPTH];

   logic                  req_acc;
   logic                  rsp_load;
   logic [ELAPSED_W-1:0]  half_dur;
   logic                  elapsed_neg;
   logic [ELAPSED_W-1:0]  elapsed_mag;
   logic [EXP_IW-1:0]     exp_idx;
   logic [SIG_IW-1:0]     sig_idx;
   logic [PERMILLE_W-1:0] on_cl;
   logic [PERMILLE_W-1:0] off_cl;
   logic                  rd_go;
   logic [LAMP_AW-1:0]    rd_addr;
   logic                  pend_last;
   logic                  lamp_old;
   logic                  lamp_new;
   logic [THR_W-1:0]      r_q;
   logic [THR_W-1:0]      to_dark;
   logic [THR_W-1:0]      to_lit;

   // Table contents are computed at elaboration.
   for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_exp_rom
      localparam logic [63:0] X_Q20 = (64'(gi) << ROM_SHIFT) / 64'(EXP_TABLE_DEPTH);
      localparam logic [63:0] E_VAL = exp_neg_q16(X_Q20);
      assign exp_rom[gi] = E_VAL[Q16_W-1:0];
   end

   for (genvar gi = 0; gi < SIG_TABLE_DEPTH; gi++) begin : g_sig_rom
      localparam logic [63:0] X_Q20 = (64'(gi) << ROM_SHIFT) / 64'(SIG_TABLE_DEPTH);
      localparam logic [63:0] S_VAL = sig_entry(exp_neg_q16(X_Q20));
      assign sig_rom[gi] = S_VAL[Q16_W-1:0];
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         end_on_ff    <= END_ON_RST;
         duration_ff  <= DURATION_RST;
         check_per_ff <= CHECK_PER_RST;
         on_floor_ff  <= ON_FLOOR_RST;
         off_start_ff <= OFF_START_RST;
         tau_on_ff    <= TAU_ON_RST;
         tau_off_ff   <= TAU_OFF_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_END_ON:    end_on_ff    <= csr_wdata[0];
            CSR_DURATION:  duration_ff  <= csr_wdata[DUR_W-1:0];
            CSR_CHECK_PER: check_per_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_ON_FLOOR:  on_floor_ff  <= csr_wdata[PERMILLE_W-1:0];
            CSR_OFF_START: off_start_ff <= csr_wdata[PERMILLE_W-1:0];
            CSR_TAU_ON:    tau_on_ff    <= csr_wdata[TAU_W-1:0];
            CSR_TAU_OFF:   tau_off_ff   <= csr_wdata[TAU_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;

   // Distance of the elapsed time from the middle of the phase.
   assign half_dur    = ELAPSED_W'(duration_ff[DUR_W-1:1]);
   assign elapsed_neg = elapsed_ff < half_dur;
   assign elapsed_mag = elapsed_neg ? (half_dur - elapsed_ff) : (elapsed_ff - half_dur);

   // Phase bookkeeping for an accepted transaction.
   always_comb begin
      mode_in    = MODE_KEEP;
      running_in = running_ff;
      elapsed_in = elapsed_ff;
      since_in   = since_ff;
      if (req_opcode == OP_START) begin
         running_in = 1'b1;
         elapsed_in = '0;
         since_in   = SINCE_MAX;
      end else if (running_ff) begin
         if (elapsed_ff > ELAPSED_W'(duration_ff)) begin
            mode_in    = MODE_FORCE;
            running_in = 1'b0;
         end else begin
            if (elapsed_ff != ELAPSED_MAX) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
            if (since_ff > SINCE_W'(check_per_ff)) begin
               // The counter restarts at zero and then advances with the tick.
               mode_in  = MODE_CHECK;
               since_in = SINCE_W'(1);
            end else if (since_ff != SINCE_MAX) begin
               since_in = since_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         elapsed_ff <= '0;
         since_ff   <= SINCE_MAX;
         mode_ff    <= MODE_KEEP;
      end else if (req_acc) begin
         running_ff <= running_in;
         elapsed_ff <= elapsed_in;
         since_ff   <= since_in;
         mode_ff    <= mode_in;
      end
   end

   // Sweep control: one lamp read per cycle, written back on the next.
   assign rd_go     = (state_ff == S_SWEEP) && (rd_cnt_ff < LAMP_CW'(NUM_LAMPS));
   assign rd_addr   = rd_cnt_ff[LAMP_AW-1:0];
   assign pend_last = pend_vld_ff && (pend_idx_ff == LAMP_AW'(NUM_LAMPS - 1));
   assign rsp_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               state_in = (mode_in == MODE_CHECK) ? S_MUL1 : S_SWEEP;
            end
         end
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_ROM;
         S_ROM:   state_in = S_THR1;
         S_THR1:  state_in = S_THR2;
         S_THR2:  state_in = S_SWEEP;
         S_SWEEP: begin
            if (pend_last) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_cnt_ff   <= '0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= rd_go;
         if (req_acc) begin
            rd_cnt_ff <= '0;
         end else if (rd_go) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
      end
   end

   // Snapshot of the transaction for the threshold pipeline and the sweep.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         rand_ff[0]      <= req_rand_lamp0;
         rand_ff[1]      <= req_rand_lamp1;
         rand_ff[2]      <= req_rand_lamp2;
         rand_ff[3]      <= req_rand_lamp3;
         elapsed_snap_ff <= elapsed_ff;
         mag_ff          <= elapsed_mag;
         neg_ff          <= elapsed_neg;
      end
   end

   // Threshold pipeline: rate products, table index scaling, table reads,
   // then the permille scaling of both curves.
   assign exp_idx = sc_off_ff[EXP_SCW-1:ROM_SHIFT];
   assign sig_idx = sc_on_ff[SIG_SCW-1:ROM_SHIFT];
   assign on_cl   = (on_floor_ff > PERMILLE_FULL) ? PERMILLE_FULL : on_floor_ff;
   assign off_cl  = (off_start_ff > PERMILLE_FULL) ? PERMILLE_FULL : off_start_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_MUL1) begin
         a_off_ff <= A_W'(elapsed_snap_ff) * A_W'(tau_off_ff);
         a_on_ff  <= A_W'(mag_ff) * A_W'(tau_on_ff);
      end
      if (state_ff == S_MUL2) begin
         sc_off_ff <= EXP_SCW'(a_off_ff) * EXP_SCW'(EXP_TABLE_DEPTH);
         sc_on_ff  <= SIG_SCW'(a_on_ff) * SIG_SCW'(SIG_TABLE_DEPTH);
      end
      if (state_ff == S_ROM) begin
         // Past the end of a table the curve has settled.
         exp_q_ff <= (exp_idx < EXP_IW'(EXP_TABLE_DEPTH)) ?
                     exp_rom[exp_idx[EXP_AW-1:0]] : '0;
         sig_q_ff <= (sig_idx < SIG_IW'(SIG_TABLE_DEPTH)) ?
                     sig_rom[sig_idx[SIG_AW-1:0]] : Q16_ONE;
      end
      if (state_ff == S_THR1) begin
         thr_off_ff <= THR_W'(off_cl) * THR_W'(exp_q_ff);
         s_adj_ff   <= neg_ff ? (Q16_ONE - sig_q_ff) : sig_q_ff;
      end
      if (state_ff == S_THR2) begin
         thr_on_ff <= (THR_W'(on_cl) << Q16_SHIFT)
                      + THR_W'(PERMILLE_FULL - on_cl) * THR_W'(s_adj_ff);
      end
   end

   // New state of the lamp whose read data has just arrived.
   assign lamp_old = lamp_rd_vld_ff && lamp_rd_ff;
   assign r_q      = THR_W'({rand_ff[2'(pend_idx_ff)], {Q16_SHIFT{1'b0}}});
   assign to_dark  = end_on_ff ? thr_off_ff : thr_on_ff;
   assign to_lit   = end_on_ff ? thr_on_ff : thr_off_ff;

   always_comb begin
      case (mode_ff)
         MODE_FORCE: lamp_new = end_on_ff;
         MODE_CHECK: lamp_new = lamp_old ? !(r_q < to_dark) : (r_q < to_lit);
         default:    lamp_new = lamp_old;
      endcase
   end

   // Lamp memory: registered read, write-back in the following cycle. Reads and
   // writes of one sweep always target different lamps.
   always_ff @(posedge clock) begin
      if (rd_go) begin
         lamp_rd_ff <= lamp_mem[rd_addr];
      end
      if (pend_vld_ff) begin
         lamp_mem[pend_idx_ff] <= lamp_new;
      end
   end

   // Valid bits stand in for the cleared memory after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_vld_ff <= '0;
      end else if (pend_vld_ff) begin
         lamp_vld_ff[pend_idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_go) begin
         lamp_rd_vld_ff <= lamp_vld_ff[rd_addr];
         pend_idx_ff    <= rd_addr;
      end
   end

   // Collect the visible lamps before and after this transaction.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         before_ff <= '0;
         after_ff  <= '0;
      end else if (pend_vld_ff && (int'(pend_idx_ff) < OUT_LAMPS)) begin
         before_ff[2'(pend_idx_ff)] <= lamp_old;
         after_ff[2'(pend_idx_ff)]  <= lamp_new;
      end
   end

   // Output register.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_states_ff  <= after_ff;
         rsp_toggled_ff <= before_ff ^ after_ff;
         rsp_checked_ff <= (mode_ff == MODE_CHECK);
         rsp_done_ff    <= !running_ff && (elapsed_ff != '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lamp_states  = rsp_states_ff;
   assign rsp_toggled_mask = rsp_toggled_ff;
   assign rsp_checked      = rsp_checked_ff;
   assign rsp_done_res     = rsp_done_ff;

endmodule

@@ hdl/lsf_checker.sv @@
// ============================================================================
// lsf_checker: port-level checks for the lamp start-up flicker block
// Watches the request and result channels and checks ordering, result
// consistency across transactions and the output handshake.
// ============================================================================
module lsf_checker
   import lsf_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [OUT_LAMPS-1:0] rsp_lamp_states,
   input logic [OUT_LAMPS-1:0] rsp_toggled_mask,
   input logic                 rsp_checked,
   input logic                 rsp_done_res
);

   logic [2:0]           open_cnt_ff;
   logic [OUT_LAMPS-1:0] last_states_ff;
   logic                 req_acc;
   logic                 rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // Transactions accepted but not yet answered, and the last lamp states seen.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_cnt_ff    <= '0;
         last_states_ff <= '0;
      end else begin
         open_cnt_ff <= open_cnt_ff + 3'(req_acc) - 3'(rsp_acc);
         if (rsp_acc) begin
            last_states_ff <= rsp_lamp_states;
         end
      end
   end

   // A stalled result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lamp_states)
         && $stable(rsp_toggled_mask) && $stable(rsp_checked) && $stable(rsp_done_res))
      else $error("result changed while stalled");

   // Every result answers an accepted transaction.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> open_cnt_ff != 3'd0)
      else $error("result without a pending transaction");

   // At most one result waits while one transaction is at work.
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_cnt_ff <= 3'd2)
      else $error("too many transactions in flight");

   // The toggle mask links each result to the one before it.
   a_toggle_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lamp_states ^ rsp_toggled_mask) == last_states_ff)
      else $error("toggle mask does not match the previous lamp states");

   // A check only runs inside the flicker phase.
   a_check_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checked |-> !rsp_done_res)
      else $error("check reported after the phase ended");

endmodule

bind lamp_startup_flicker_core lsf_checker u_lsf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_lamp_states  (rsp_lamp_states),
   .rsp_toggled_mask (rsp_toggled_mask),
   .rsp_checked      (rsp_checked),
   .rsp_done_res     (rsp_done_res)
);

@@ sim/tb_lamp_startup_flicker_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_lamp_startup_flicker_core: self-checking bench for the flicker sequencer
// Drives start and tick transactions with random lamp draws, mirrors the
// elapsed-time, check-period and threshold logic in a local predictor with
// its own lookup tables, and compares every result transaction field by
// field. Configuration is rewritten between phases while the block is idle.
// ============================================================================
module tb_lamp_startup_flicker_core;
   import lsf_pkg::*;

   localparam int      HALF_PERIOD    = 10;
   localparam longint  TIMEOUT_NS     = 64'd400_000 * 2 * HALF_PERIOD;
   localparam int      SETTLE_CYCLES  = 24;
   localparam int      RANDOM_PHASES  = 16;
   localparam int      PHASE_ITEMS    = 22;
   localparam int      LONG_TICKS     = 270;

   // Idling patterns of the two channels.
   localparam int      IDLE_NONE      = 0;
   localparam int      IDLE_SENDER    = 1;
   localparam int      IDLE_RECEIVER  = 2;
   localparam int      IDLE_BOTH      = 3;

   typedef logic [OUT_LAMPS-1:0][RAND_W-1:0] draw_set_type;

   typedef struct packed {
      logic [OUT_LAMPS-1:0] lamps;
      logic [OUT_LAMPS-1:0] toggled;
      logic                 checked;
      logic                 done;
   } lamp_result_type;

   typedef struct packed {
      logic                  end_on;
      logic [DUR_W-1:0]      duration;
      logic [PERIOD_W-1:0]   period;
      logic [PERMILLE_W-1:0] on_floor;
      logic [PERMILLE_W-1:0] off_start;
      logic [TAU_W-1:0]      tau_on;
      logic [TAU_W-1:0]      tau_off;
   } flicker_cfg_type;

   // Clock, reset and block inputs, all known from time zero.
   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic                  req_opcode     = OP_START;
   logic [RAND_W-1:0]     req_rand_lamp0 = '0;
   logic [RAND_W-1:0]     req_rand_lamp1 = '0;
   logic [RAND_W-1:0]     req_rand_lamp2 = '0;
   logic [RAND_W-1:0]     req_rand_lamp3 = '0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [OUT_LAMPS-1:0]  rsp_lamp_states;
   logic [OUT_LAMPS-1:0]  rsp_toggled_mask;
   logic                  rsp_checked;
   logic                  rsp_done_res;
   logic                  csr_we         = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr       = CSR_END_ON;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;

   // Predictor state and configuration.
   flicker_cfg_type      active_cfg;
   logic [OUT_LAMPS-1:0] lit_mask;
   logic [ELAPSED_W-1:0] phase_ms;
   logic [SINCE_W-1:0]   ms_since_check;
   logic                 phase_active;
   logic [Q16_W-1:0]     decay_tbl [EXP_DEPTH_DEFAULT];
   logic [Q16_W-1:0]     logistic_tbl [SIG_DEPTH_DEFAULT];

   lamp_result_type pending_results[$];
   int              error_count    = 0;
   int              active_items   = 0;
   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;

   lamp_startup_flicker_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_rand_lamp0   (req_rand_lamp0),
      .req_rand_lamp1   (req_rand_lamp1),
      .req_rand_lamp2   (req_rand_lamp2),
      .req_rand_lamp3   (req_rand_lamp3),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_lamp_states  (rsp_lamp_states),
      .rsp_toggled_mask (rsp_toggled_mask),
      .rsp_checked      (rsp_checked),
      .rsp_done_res     (rsp_done_res),
      .csr_we           (csr_we),
      .csr_addr         (csr_addr),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Lookup tables
   // ---------------------------------------------------------------------

   // exp(-x) in Q16 for x in Q20: Taylor series of exp(-x/256) in Q30,
   // then eight rounded squarings.
   function automatic logic [63:0] neg_exp_q16(input logic [63:0] x_q20);
      logic [63:0] u;
      logic [63:0] acc;
      logic [63:0] term;
      int          k;
      u    = x_q20 << 2;
      acc  = 64'd1 << 30;
      term = acc;
      for (k = 1; k <= 5; k++) begin
         term = ((term * u) >> 30) / 64'(k);
         if (k % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      for (k = 0; k < 8; k++) begin
         acc = (acc * acc + (64'd1 << 29)) >> 30;
      end
      return (acc + 64'd8192) >> 14;
   endfunction

   task automatic build_tables();
      logic [63:0] x;
      logic [63:0] e;
      int          i;
      for (i = 0; i < EXP_DEPTH_DEFAULT; i++) begin
         x = (64'(i) << ROM_SHIFT) / EXP_DEPTH_DEFAULT;
         e = neg_exp_q16(x);
         decay_tbl[i] = e[Q16_W-1:0];
      end
      for (i = 0; i < SIG_DEPTH_DEFAULT; i++) begin
         x = (64'(i) << ROM_SHIFT) / SIG_DEPTH_DEFAULT;
         e = (64'd1 << 32) / (64'(Q16_ONE) + neg_exp_q16(x));
         logistic_tbl[i] = e[Q16_W-1:0];
      end
   endtask

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic logic [63:0] cap_permille(input logic [PERMILLE_W-1:0] v);
      return (v > PERMILLE_FULL) ? 64'(PERMILLE_FULL) : 64'(v);
   endfunction

   // Turn-on level: logistic curve centered on half the duration.
   function automatic logic [63:0] rise_level();
      logic [63:0] half;
      logic [63:0] mag;
      logic [63:0] idx;
      logic [63:0] s;
      logic [63:0] f;
      logic        early;
      half  = 64'(active_cfg.duration >> 1);
      early = 64'(phase_ms) < half;
      mag   = early ? half - 64'(phase_ms) : 64'(phase_ms) - half;
      idx   = (mag * 64'(active_cfg.tau_on) * SIG_DEPTH_DEFAULT) >> ROM_SHIFT;
      s     = (idx < SIG_DEPTH_DEFAULT) ? 64'(logistic_tbl[idx]) : 64'(Q16_ONE);
      if (early) begin
         s = 64'(Q16_ONE) - s;
      end
      f = cap_permille(active_cfg.on_floor);
      return f * 64'(Q16_ONE) + (64'(PERMILLE_FULL) - f) * s;
   endfunction

   // Turn-off level: decaying exponential scaled by the start permille.
   function automatic logic [63:0] fall_level();
      logic [63:0] idx;
      logic [63:0] e;
      idx = (64'(phase_ms) * 64'(active_cfg.tau_off) * EXP_DEPTH_DEFAULT) >> ROM_SHIFT;
      e   = (idx < EXP_DEPTH_DEFAULT) ? 64'(decay_tbl[idx]) : 64'd0;
      return cap_permille(active_cfg.off_start) * e;
   endfunction

   // Advance the predictor by one accepted transaction.
   task automatic flicker_step(input logic opcode, input draw_set_type draws,
                               output lamp_result_type outcome);
      logic [OUT_LAMPS-1:0] prior;
      logic                 ran_check;
      logic [63:0]          lit_level;
      logic [63:0]          dark_level;
      logic [63:0]          to_dark;
      logic [63:0]          to_lit;
      logic [63:0]          scaled;
      int                   i;
      prior     = lit_mask;
      ran_check = 1'b0;
      if (opcode == OP_START) begin
         phase_ms       = '0;
         ms_since_check = SINCE_MAX;
         phase_active   = 1'b1;
      end else if (phase_active) begin
         if (phase_ms > active_cfg.duration) begin
            // Phase ran out: every lamp takes the final state.
            lit_mask     = {OUT_LAMPS{active_cfg.end_on}};
            phase_active = 1'b0;
         end else begin
            if (ms_since_check > active_cfg.period) begin
               lit_level      = rise_level();
               dark_level     = fall_level();
               to_dark        = active_cfg.end_on ? dark_level : lit_level;
               to_lit         = active_cfg.end_on ? lit_level : dark_level;
               ms_since_check = '0;
               ran_check      = 1'b1;
               for (i = 0; i < OUT_LAMPS; i++) begin
                  scaled = 64'(draws[i]) << Q16_SHIFT;
                  if (lit_mask[i]) begin
                     if (scaled < to_dark) begin
                        lit_mask[i] = 1'b0;
                     end
                  end else if (scaled < to_lit) begin
                     lit_mask[i] = 1'b1;
                  end
               end
            end
            if (phase_ms != ELAPSED_MAX) begin
               phase_ms = phase_ms + 1'b1;
            end
            if (ms_since_check != SINCE_MAX) begin
               ms_since_check = ms_since_check + 1'b1;
            end
         end
      end
      outcome.lamps   = lit_mask;
      outcome.toggled = prior ^ lit_mask;
      outcome.checked = ran_check;
      outcome.done    = !phase_active && (phase_ms != '0);
   endtask

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------

   // Idle the sender at random, then hold one transaction until accepted.
   task automatic send_item(input logic opcode, input draw_set_type draws);
      lamp_result_type outcome;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= opcode;
      req_rand_lamp0 <= draws[0];
      req_rand_lamp1 <= draws[1];
      req_rand_lamp2 <= draws[2];
      req_rand_lamp3 <= draws[3];
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (opcode == OP_START || phase_active) begin
         active_items++;
      end
      flicker_step(opcode, draws, outcome);
      pending_results.push_back(outcome);
   endtask

   // Stop sending and wait until every expected result has come back.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Write all seven registers back to back; call only while idle.
   task automatic load_config(input flicker_cfg_type cfg);
      write_register(CSR_END_ON,    CSR_DATA_W'(cfg.end_on));
      write_register(CSR_DURATION,  CSR_DATA_W'(cfg.duration));
      write_register(CSR_CHECK_PER, CSR_DATA_W'(cfg.period));
      write_register(CSR_ON_FLOOR,  CSR_DATA_W'(cfg.on_floor));
      write_register(CSR_OFF_START, CSR_DATA_W'(cfg.off_start));
      write_register(CSR_TAU_ON,    CSR_DATA_W'(cfg.tau_on));
      write_register(CSR_TAU_OFF,   CSR_DATA_W'(cfg.tau_off));
      csr_we     <= 1'b0;
      active_cfg  = cfg;
   endtask

   // Mostly the usual 1..999 draws, sometimes anything the field holds.
   function automatic draw_set_type random_draws();
      draw_set_type draws;
      int           i;
      for (i = 0; i < OUT_LAMPS; i++) begin
         if ($urandom_range(4) == 0) begin
            draws[i] = RAND_W'($urandom_range(1023));
         end else begin
            draws[i] = RAND_W'($urandom_range(999, 1));
         end
      end
      return draws;
   endfunction

   task automatic set_idle_mode(input int mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct  = 53;
            recv_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct  = 0;
            recv_stall_pct = 53;
         end
         default: begin
            send_idle_pct  = 22;
            recv_stall_pct = 22;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Ticks before any start must leave everything untouched.
   task automatic test_idle_ticks();
      send_item(OP_TICK, '0);
      send_item(OP_TICK, '1);
   endtask

   // Reset configuration, draw extremes, and a restart in mid-phase.
   task automatic test_default_run();
      send_item(OP_START, {10'd1000, 10'd999, 10'd1023, 10'd0});
      send_item(OP_TICK,  {10'd1000, 10'd999, 10'd1023, 10'd0});
      send_item(OP_TICK,  {10'd1, 10'd500, 10'd998, 10'd1023});
      send_item(OP_TICK,  '0);
      send_item(OP_TICK,  '1);
      send_item(OP_START, random_draws());
      send_item(OP_TICK,  '0);
      send_item(OP_TICK,  {10'd999, 10'd1, 10'd0, 10'd1000});
   endtask

   // Every register at zero: zero duration ends on the second tick.
   task automatic test_floor_config();
      flicker_cfg_type cfg;
      cfg = '0;
      settle();
      load_config(cfg);
      send_item(OP_START, '1);
      send_item(OP_TICK,  {10'd0, 10'd1023, 10'd499, 10'd500});
      send_item(OP_TICK,  '0);
      send_item(OP_TICK,  '1);
      send_item(OP_START, '0);
   endtask

   // Every register at its top value; permille values above 1000 clamp.
   task automatic test_ceiling_config();
      flicker_cfg_type cfg;
      cfg.end_on    = 1'b1;
      cfg.duration  = '1;
      cfg.period    = '1;
      cfg.on_floor  = '1;
      cfg.off_start = '1;
      cfg.tau_on    = '1;
      cfg.tau_off   = '1;
      settle();
      load_config(cfg);
      send_item(OP_START, '0);
      send_item(OP_TICK,  {10'd1000, 10'd999, 10'd1023, 10'd0});
      send_item(OP_TICK,  {10'd1000, 10'd999, 10'd1023, 10'd0});
      send_item(OP_TICK,  '1);
   endtask

   // Long phase with steep rates so both curves run past their tables.
   task automatic test_long_phase();
      flicker_cfg_type cfg;
      cfg.end_on    = 1'b1;
      cfg.duration  = 16'd1100;
      cfg.period    = 8'($urandom_range(3));
      cfg.on_floor  = ON_FLOOR_RST;
      cfg.off_start = OFF_START_RST;
      cfg.tau_on    = '1;
      cfg.tau_off   = '1;
      set_idle_mode(IDLE_BOTH);
      settle();
      load_config(cfg);
      send_item(OP_START, random_draws());
      repeat (LONG_TICKS) send_item(OP_TICK, random_draws());
   endtask

   // Random configurations, each driven mostly with complete start/tick
   // sequences, mixed with cut-short phases, restarts and stray ticks.
   task automatic test_random_phases();
      flicker_cfg_type cfg;
      int              phase;
      int              goal;
      int              ticks;
      int              choice;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_idle_mode(phase % 4);
         settle();
         cfg.end_on    = 1'($urandom_range(1));
         cfg.duration  = ($urandom_range(7) == 0) ? '0 : DUR_W'($urandom_range(24));
         cfg.period    = ($urandom_range(3) == 0) ? PERIOD_W'($urandom_range(255))
                                                  : PERIOD_W'($urandom_range(4));
         cfg.on_floor  = ($urandom_range(5) == 0) ? PERMILLE_W'($urandom_range(1023))
                                                  : PERMILLE_W'($urandom_range(1000));
         cfg.off_start = ($urandom_range(5) == 0) ? PERMILLE_W'($urandom_range(1023))
                                                  : PERMILLE_W'($urandom_range(1000));
         cfg.tau_on    = TAU_W'($urandom_range(65535));
         cfg.tau_off   = TAU_W'($urandom_range(65535));
         load_config(cfg);
         goal = active_items + PHASE_ITEMS;
         while (active_items < goal) begin
            choice = $urandom_range(9);
            if (choice == 0) begin
               send_item(OP_TICK, random_draws());
            end else if (choice == 1) begin
               send_item(OP_START, random_draws());
            end else begin
               if ($urandom_range(4) == 0) begin
                  ticks = $urandom_range(cfg.duration);
               end else begin
                  ticks = cfg.duration + 2 + $urandom_range(2);
               end
               send_item(OP_START, random_draws());
               repeat (ticks) send_item(OP_TICK, random_draws());
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Random stalls on the result channel.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Compare each accepted result transaction with the oldest expectation.
   always @(posedge clock) begin
      lamp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time,
                     {rsp_lamp_states, rsp_toggled_mask, rsp_checked, rsp_done_res});
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("lamp_states",  want.lamps,   rsp_lamp_states);
            check_field("toggled_mask", want.toggled, rsp_toggled_mask);
            check_field("checked",      want.checked, rsp_checked);
            check_field("done_res",     want.done,    rsp_done_res);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      active_cfg     = '{END_ON_RST, DURATION_RST, CHECK_PER_RST, ON_FLOOR_RST,
                         OFF_START_RST, TAU_ON_RST, TAU_OFF_RST};
      lit_mask       = '0;
      phase_ms       = '0;
      ms_since_check = SINCE_MAX;
      phase_active   = 1'b0;
      build_tables();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      set_idle_mode(IDLE_BOTH);
      test_idle_ticks();
      test_default_run();
      test_floor_config();
      test_ceiling_config();
      test_long_phase();
      test_random_phases();

      settle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog in case the handshake hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule
